// ----- rtl/core/shape_fill_framebuffer_macros.svh -----
// assertion macros shared by the framebuffer rtl
// clocked, disabled while the synchronous reset is low
`ifndef SHAPE_FILL_FRAMEBUFFER_MACROS_SVH
`define SHAPE_FILL_FRAMEBUFFER_MACROS_SVH

// same-cycle implication
`define SFF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/sff_pkg.sv -----
// shared constants, types and address helper for the framebuffer
// no dependencies
`timescale 1ns / 1ps

package sff_pkg;

    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int CELLS         = SCREEN_WIDTH * SCREEN_HEIGHT;

    localparam int XW    = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
    localparam int YW    = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    // signed working width for clip and edge arithmetic
    localparam int CRD_W = 12;

    localparam logic [7:0] BLANK_CELL = 8'h20;

    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_PIXEL  = 3'd1;
    localparam logic [2:0] OP_RECT   = 3'd2;
    localparam logic [2:0] OP_CIRCLE = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    typedef logic [AW-1:0] t_addr;
    typedef logic [7:0]    t_cell;

    typedef struct packed {
        logic  en;
        t_addr addr;
        t_cell data;
    } t_wr_req;

    // row major cell address, multiply by a constant
    function automatic t_addr cell_addr(input logic [YW-1:0] y, input logic [XW-1:0] x);
        return t_addr'(int'(y) * SCREEN_WIDTH + int'(x));
    endfunction

endpackage

// ----- rtl/core/sff_frame_ram.sv -----
// character store: one write port, one registered read port
// depends on sff_pkg
`timescale 1ns / 1ps

module sff_frame_ram import sff_pkg::*; (
    input  logic    i_clk,
    input  t_wr_req i_wr,
    input  t_addr   i_rd_addr,
    output t_cell   o_rd_data
);

    t_cell r_mem [CELLS];
    t_cell r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/shape_fill_framebuffer.sv -----
// Character framebuffer of SCREEN_WIDTH x SCREEN_HEIGHT 8-bit cells (64 x 32 by
// default) with a small fill engine. Each input beat is one command: clear the
// store to spaces, plot one clipped pixel, fill a clipped rectangle or circle
// (fill byte inside, border byte in an outline band of border_thickness cells),
// or read one cell. Only a read returns an output beat; an off-screen read
// returns a space. Commands are handled one at a time and o_in_stall is high
// until the current one is done. A clear writes one cell a cycle. A rectangle
// or pixel goes through a clip step and then, for each row of its clipped box,
// a row step and one step per cell; a circle adds a radius squared and an inner
// radius squared step before the rows. Every cell of the clipped box is visited
// once through the single write port of the store and the circle test goes
// through one shared squaring unit (radius squared, inner radius squared, one
// row term per row, one column term per cell). A read goes through the
// registered read port, and waits there while a previous read beat is still
// stalled in the output register. Unused operation codes are taken and do
// nothing. After reset the store is swept to spaces, one cell a cycle, and no
// command is taken until that finishes.
// Depends on sff_pkg, sff_frame_ram and shape_fill_framebuffer_macros.svh.
`timescale 1ns / 1ps
`include "shape_fill_framebuffer_macros.svh"

module shape_fill_framebuffer import sff_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [2:0]        i_operation,
    input  logic signed [9:0] i_pos_x,
    input  logic signed [9:0] i_pos_y,
    input  logic [8:0]        i_rect_width,
    input  logic [8:0]        i_rect_height,
    input  logic [7:0]        i_circle_radius,
    input  logic [7:0]        i_fill_byte,
    input  logic [7:0]        i_border_byte,
    input  logic [7:0]        i_border_thickness,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_cell_value
);

    // sequencer states
    localparam logic [3:0] S_CLEAR = 4'd0;  // sweep store to spaces
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SETUP = 4'd2;  // clip the box
    localparam logic [3:0] S_SQ_R  = 4'd3;  // radius squared
    localparam logic [3:0] S_SQ_Q  = 4'd4;  // inner radius squared
    localparam logic [3:0] S_ROW   = 4'd5;  // per-row terms
    localparam logic [3:0] S_CELL  = 4'd6;  // one cell per cycle
    localparam logic [3:0] S_RD1   = 4'd7;  // read address at the store
    localparam logic [3:0] S_RD2   = 4'd8;  // read data back, load output

    localparam logic signed [CRD_W-1:0] SCR_W = CRD_W'(SCREEN_WIDTH);
    localparam logic signed [CRD_W-1:0] SCR_H = CRD_W'(SCREEN_HEIGHT);
    localparam logic signed [CRD_W-1:0] ONE_C = CRD_W'(1);

    // control state
    logic [3:0]    r_state, n_state;
    t_addr         r_clr_addr, n_clr_addr;
    logic [YW-1:0] r_i, n_i;
    logic [XW-1:0] r_j, n_j;
    logic          r_out_valid, n_out_valid;

    // command payload
    logic              r_is_circ;
    logic signed [9:0] r_px, r_py;
    logic [9:0]        r_w, r_h;
    logic [7:0]        r_r, r_t;
    t_cell             r_fill, r_border;
    logic              r_rd_on;
    t_addr             r_rd_addr;
    t_cell             r_cell_value;

    // clip box and shared-unit results
    logic [XW-1:0] r_xfirst, r_xlast;
    logic [YW-1:0] r_ylast;
    logic [16:0]   r_rr, r_qq, r_di2;
    logic          r_row_edge;

    logic              w_accept;
    logic              w_out_free;
    logic signed [CRD_W-1:0] w_sx, w_sy, w_ex, w_ey;
    logic signed [CRD_W-1:0] w_x0, w_y0, w_x1, w_y1, w_x1m1, w_y1m1;
    logic              w_empty;
    logic [7:0]        w_q;
    logic signed [CRD_W-1:0] w_cx, w_cy, w_i_s, w_j_s, w_di, w_dj, w_tt;
    logic signed [8:0] w_sq_in;
    logic signed [17:0] w_prod;
    logic [16:0]       w_sq;
    logic [17:0]       w_d2;
    logic              w_in_circ, w_circ_border;
    logic              w_row_edge, w_col_edge;
    logic              w_rd_on;
    t_wr_req           w_wr;
    t_cell             w_rd_data;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // clipping of the shape box against the screen, end is exclusive
    assign w_sx   = CRD_W'(r_px);
    assign w_sy   = CRD_W'(r_py);
    assign w_ex   = w_sx + $signed(CRD_W'(r_w));
    assign w_ey   = w_sy + $signed(CRD_W'(r_h));
    assign w_x0   = w_sx[CRD_W-1] ? '0 : w_sx;
    assign w_y0   = w_sy[CRD_W-1] ? '0 : w_sy;
    assign w_x1   = (w_ex > SCR_W) ? SCR_W : w_ex;
    assign w_y1   = (w_ey > SCR_H) ? SCR_H : w_ey;
    assign w_x1m1 = w_x1 - ONE_C;
    assign w_y1m1 = w_y1 - ONE_C;
    assign w_empty = (w_x1 <= w_x0) || (w_y1 <= w_y0);

    // circle geometry; inner radius floors at zero for a thick outline
    assign w_q   = (r_r > r_t) ? (r_r - r_t) : 8'd0;
    assign w_cx  = w_sx + $signed(CRD_W'(r_r));
    assign w_cy  = w_sy + $signed(CRD_W'(r_r));
    assign w_i_s = $signed(CRD_W'(r_i));
    assign w_j_s = $signed(CRD_W'(r_j));
    assign w_di  = w_i_s - w_cy;
    assign w_dj  = w_j_s - w_cx;

    // shared squaring unit, operand chosen by the sequencer
    always_comb begin
        unique case (r_state)
            S_SQ_R:  w_sq_in = $signed({1'b0, r_r});
            S_SQ_Q:  w_sq_in = $signed({1'b0, w_q});
            S_ROW:   w_sq_in = w_di[8:0];
            default: w_sq_in = w_dj[8:0];
        endcase
    end

    assign w_prod = w_sq_in * w_sq_in;
    assign w_sq   = w_prod[16:0];

    assign w_d2          = {1'b0, r_di2} + {1'b0, w_sq};
    assign w_in_circ     = (w_d2 <= {1'b0, r_rr});
    assign w_circ_border = (w_d2 > {1'b0, r_qq});

    // rectangle frame: distance to any unclipped edge below the thickness
    assign w_tt       = $signed(CRD_W'(r_t));
    assign w_row_edge = ((w_i_s - w_sy) < w_tt) || ((w_ey - ONE_C - w_i_s) < w_tt);
    assign w_col_edge = ((w_j_s - w_sx) < w_tt) || ((w_ex - ONE_C - w_j_s) < w_tt);

    // read position check on the incoming beat
    assign w_rd_on = !i_pos_x[9] && !i_pos_y[9] &&
                     (CRD_W'(i_pos_x) < SCR_W) && (CRD_W'(i_pos_y) < SCR_H);

    // store write port
    always_comb begin
        w_wr.addr = cell_addr(r_i, r_j);
        w_wr.en   = 1'b0;
        w_wr.data = r_fill;
        unique case (r_state)
            S_CLEAR: begin
                w_wr.en   = 1'b1;
                w_wr.addr = r_clr_addr;
                w_wr.data = BLANK_CELL;
            end
            S_CELL: begin
                if (r_is_circ) begin
                    w_wr.en   = w_in_circ;
                    w_wr.data = w_circ_border ? r_border : r_fill;
                end else begin
                    w_wr.en   = 1'b1;
                    w_wr.data = (r_row_edge || w_col_edge) ? r_border : r_fill;
                end
            end
            default: begin
                w_wr.en = 1'b0;
            end
        endcase
    end

    sff_frame_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_i         = r_i;
        n_j         = r_j;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + t_addr'(1);
                if (r_clr_addr == t_addr'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_operation)
                        OP_CLEAR: begin
                            n_state    = S_CLEAR;
                            n_clr_addr = '0;
                        end
                        OP_PIXEL, OP_RECT, OP_CIRCLE: n_state = S_SETUP;
                        OP_READ:  n_state = S_RD1;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_SETUP: begin
                if (w_empty) begin
                    n_state = S_IDLE;
                end else begin
                    n_i     = w_y0[YW-1:0];
                    n_state = r_is_circ ? S_SQ_R : S_ROW;
                end
            end
            S_SQ_R: n_state = S_SQ_Q;
            S_SQ_Q: n_state = S_ROW;
            S_ROW: begin
                n_j     = r_xfirst;
                n_state = S_CELL;
            end
            S_CELL: begin
                if (r_j == r_xlast) begin
                    if (r_i == r_ylast) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + YW'(1);
                        n_state = S_ROW;
                    end
                end else begin
                    n_j = r_j + XW'(1);
                end
            end
            S_RD1: n_state = S_RD2;
            S_RD2: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_i         <= n_i;
            r_j         <= n_j;
            r_out_valid <= n_out_valid;
        end
    end

    // payload and datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_px      <= i_pos_x;
            r_py      <= i_pos_y;
            r_fill    <= i_fill_byte;
            r_border  <= i_border_byte;
            r_r       <= i_circle_radius;
            r_is_circ <= (i_operation == OP_CIRCLE);
            r_rd_on   <= w_rd_on;
            r_rd_addr <= cell_addr(i_pos_y[YW-1:0], i_pos_x[XW-1:0]);
            // a pixel is a one-cell box without a frame
            if (i_operation == OP_PIXEL) begin
                r_w <= 10'd1;
                r_h <= 10'd1;
                r_t <= 8'd0;
            end else if (i_operation == OP_CIRCLE) begin
                r_w <= {1'b0, i_circle_radius, 1'b0};
                r_h <= {1'b0, i_circle_radius, 1'b0};
                r_t <= i_border_thickness;
            end else begin
                r_w <= {1'b0, i_rect_width};
                r_h <= {1'b0, i_rect_height};
                r_t <= i_border_thickness;
            end
        end
        if (r_state == S_SETUP) begin
            r_xfirst <= w_x0[XW-1:0];
            r_xlast  <= w_x1m1[XW-1:0];
            r_ylast  <= w_y1m1[YW-1:0];
        end
        if (r_state == S_SQ_R) begin
            r_rr <= w_sq;
        end
        if (r_state == S_SQ_Q) begin
            r_qq <= w_sq;
        end
        if (r_state == S_ROW) begin
            r_di2      <= w_sq;
            r_row_edge <= w_row_edge;
        end
        if ((r_state == S_RD2) && w_out_free) begin
            r_cell_value <= r_rd_on ? w_rd_data : BLANK_CELL;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_value = r_cell_value;

    // checks
    `SFF_ASSERT_IMP(a_wr_in_range, i_clk, i_rst_n, w_wr.en, w_wr.addr <= t_addr'(CELLS - 1), "store write beyond last cell")
    `SFF_ASSERT_IMP(a_col_in_box, i_clk, i_rst_n, r_state == S_CELL, (r_j >= r_xfirst) && (r_j <= r_xlast), "column outside clipped box")
    `SFF_ASSERT_NXT(a_rd_done, i_clk, i_rst_n, (r_state == S_RD2) && w_out_free, o_out_valid && (r_state == S_IDLE), "read beat not presented")

endmodule

// ----- dv/shape_fill_framebuffer_checker.sv -----
// shadow-frame checker for the character framebuffer: watches both beat channels,
// keeps its own copy of the cell store and compares every cell_value beat in order
// depends on sff_pkg
`timescale 1ns / 1ps

module shape_fill_framebuffer_checker import sff_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [2:0]        i_operation,
    input  logic signed [9:0] i_pos_x,
    input  logic signed [9:0] i_pos_y,
    input  logic [8:0]        i_rect_width,
    input  logic [8:0]        i_rect_height,
    input  logic [7:0]        i_circle_radius,
    input  logic [7:0]        i_fill_byte,
    input  logic [7:0]        i_border_byte,
    input  logic [7:0]        i_border_thickness,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [7:0]        i_cell_value,
    output int                o_fail_count,
    output int                o_reads_outstanding,
    output int                o_cells_checked
);

    logic [7:0] shadow_cells [CELLS];
    logic [7:0] cells_due [$];
    logic [7:0] wanted_cell;
    int         fails   = 0;
    int         checked = 0;

    function automatic bit on_screen(int x, int y);
        return x >= 0 && y >= 0 && x < SCREEN_WIDTH && y < SCREEN_HEIGHT;
    endfunction

    function automatic void put_cell(int x, int y, logic [7:0] v);
        if (on_screen(x, y)) begin
            shadow_cells[y * SCREEN_WIDTH + x] = v;
        end
    endfunction

    // applies one accepted command to the shadow frame, queues the cell a read returns
    function automatic void draw_command(logic [2:0] op, int px, int py, int w, int h,
                                        int r, logic [7:0] fill, logic [7:0] border, int t);
        int  x0, x1, y0, y1, cx, cy, q, d2;
        bit  in_band;
        case (op)
            OP_CLEAR: begin
                foreach (shadow_cells[k]) shadow_cells[k] = BLANK_CELL;
            end
            OP_PIXEL: begin
                put_cell(px, py, fill);
            end
            OP_RECT: begin
                y0 = (py > 0) ? py : 0;
                y1 = (py + h < SCREEN_HEIGHT) ? py + h : SCREEN_HEIGHT;
                x0 = (px > 0) ? px : 0;
                x1 = (px + w < SCREEN_WIDTH) ? px + w : SCREEN_WIDTH;
                for (int i = y0; i < y1; i++) begin
                    for (int j = x0; j < x1; j++) begin
                        // band measured from the unclipped edges
                        in_band = (i - py) < t || (j - px) < t ||
                                  (py + h - 1 - i) < t || (px + w - 1 - j) < t;
                        put_cell(j, i, in_band ? border : fill);
                    end
                end
            end
            OP_CIRCLE: begin
                cx = px + r;
                cy = py + r;
                q  = (r > t) ? r - t : 0;
                y0 = (py > 0) ? py : 0;
                y1 = (py + 2 * r < SCREEN_HEIGHT) ? py + 2 * r : SCREEN_HEIGHT;
                x0 = (px > 0) ? px : 0;
                x1 = (px + 2 * r < SCREEN_WIDTH) ? px + 2 * r : SCREEN_WIDTH;
                for (int i = y0; i < y1; i++) begin
                    for (int j = x0; j < x1; j++) begin
                        d2 = (i - cy) * (i - cy) + (j - cx) * (j - cx);
                        if (d2 <= r * r) begin
                            put_cell(j, i, (d2 > q * q) ? border : fill);
                        end
                    end
                end
            end
            OP_READ: begin
                if (on_screen(px, py)) begin
                    cells_due.push_back(shadow_cells[py * SCREEN_WIDTH + px]);
                end else begin
                    cells_due.push_back(BLANK_CELL);
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (shadow_cells[k]) shadow_cells[k] = BLANK_CELL;
            cells_due.delete();
        end else begin
            // output first: a read taken this edge cannot already be on the output
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (cells_due.size() == 0) begin
                    $error("cell_value beat with no read waiting: actual %02h", i_cell_value);
                    fails++;
                end else begin
                    wanted_cell = cells_due.pop_front();
                    checked++;
                    if (i_cell_value !== wanted_cell) begin
                        $error("cell_value mismatch: expected %02h, actual %02h",
                               wanted_cell, i_cell_value);
                        fails++;
                    end
                end
            end
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0) begin
                draw_command(i_operation, int'(i_pos_x), int'(i_pos_y), int'(i_rect_width),
                             int'(i_rect_height), int'(i_circle_radius), i_fill_byte,
                             i_border_byte, int'(i_border_thickness));
            end
        end
        o_fail_count        <= fails;
        o_reads_outstanding <= cells_due.size();
        o_cells_checked     <= checked;
    end

endmodule

// ----- dv/tb_shape_fill_framebuffer.sv -----
// top of the framebuffer bench: clock, reset, command stimulus, read-side stalls,
// idle watchdog and verdict; the shadow-frame checker sits beside the block
// depends on sff_pkg, shape_fill_framebuffer and shape_fill_framebuffer_checker
`timescale 1ns / 1ps

module tb_shape_fill_framebuffer;
    import sff_pkg::*;

    localparam realtime CLK_HALF     = 6.0;
    localparam int      RESET_CYCLES = 12;
    // commands that draw, clear or read; spare opcodes come on top
    localparam int      ITEM_TARGET  = 290;
    // long receiver hold-off so reads pile up behind the output register
    localparam int      HOLD_OFF     = 400;
    // slowest command is a full-screen circle
    localparam int      DRAIN_CYCLES = 2200;
    // covers the reset sweep, a full-screen fill and the hold-off with room to spare
    localparam int      IDLE_LIMIT   = 20000;

    // opcodes the block takes and ignores
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    typedef struct {
        logic [2:0]        op;
        logic signed [9:0] pos_x;
        logic signed [9:0] pos_y;
        logic [8:0]        width;
        logic [8:0]        height;
        logic [7:0]        radius;
        logic [7:0]        fill;
        logic [7:0]        border;
        logic [7:0]        thickness;
    } t_draw_cmd;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [2:0]        i_operation;
    logic signed [9:0] i_pos_x;
    logic signed [9:0] i_pos_y;
    logic [8:0]        i_rect_width;
    logic [8:0]        i_rect_height;
    logic [7:0]        i_circle_radius;
    logic [7:0]        i_fill_byte;
    logic [7:0]        i_border_byte;
    logic [7:0]        i_border_thickness;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [7:0]        o_cell_value;

    int fail_count;
    int reads_outstanding;
    int cells_checked;

    int commands_sent = 0;
    int sent_by_op [8];
    int burst_left    = 0;
    int idle_cycles   = 0;
    bit pressure_req  = 1'b0;

    always #(CLK_HALF) i_clk = ~i_clk;

    shape_fill_framebuffer dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_operation        (i_operation),
        .i_pos_x            (i_pos_x),
        .i_pos_y            (i_pos_y),
        .i_rect_width       (i_rect_width),
        .i_rect_height      (i_rect_height),
        .i_circle_radius    (i_circle_radius),
        .i_fill_byte        (i_fill_byte),
        .i_border_byte      (i_border_byte),
        .i_border_thickness (i_border_thickness),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_cell_value       (o_cell_value)
    );

    shape_fill_framebuffer_checker u_frame_check (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_stall          (o_in_stall),
        .i_operation         (i_operation),
        .i_pos_x             (i_pos_x),
        .i_pos_y             (i_pos_y),
        .i_rect_width        (i_rect_width),
        .i_rect_height       (i_rect_height),
        .i_circle_radius     (i_circle_radius),
        .i_fill_byte         (i_fill_byte),
        .i_border_byte       (i_border_byte),
        .i_border_thickness  (i_border_thickness),
        .i_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .i_cell_value        (o_cell_value),
        .o_fail_count        (fail_count),
        .o_reads_outstanding (reads_outstanding),
        .o_cells_checked     (cells_checked)
    );

    function automatic t_draw_cmd make_cmd(logic [2:0] op, int x, int y, int w, int h,
                                           int r, int fill, int border, int thick);
        t_draw_cmd c;
        c.op        = op;
        c.pos_x     = x[9:0];
        c.pos_y     = y[9:0];
        c.width     = w[8:0];
        c.height    = h[8:0];
        c.radius    = r[7:0];
        c.fill      = fill[7:0];
        c.border    = border[7:0];
        c.thickness = thick[7:0];
        return c;
    endfunction

    // offers one command and holds it until the block takes it; afterwards either
    // carries on with the burst or drops valid for a random gap
    task automatic offer_command(input t_draw_cmd c, input bit back_to_back);
        i_operation        <= c.op;
        i_pos_x            <= c.pos_x;
        i_pos_y            <= c.pos_y;
        i_rect_width       <= c.width;
        i_rect_height      <= c.height;
        i_circle_radius    <= c.radius;
        i_fill_byte        <= c.fill;
        i_border_byte      <= c.border;
        i_border_thickness <= c.thickness;
        i_in_valid         <= 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sent_by_op[c.op]++;
        if (c.op <= OP_READ) begin
            commands_sent++;
        end
        if (!back_to_back) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                // now and then a long unbroken run
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(0, 6);
            end
        end
    endtask

    // stimulus
    initial begin
        t_draw_cmd c;
        int        pick;
        int        near_x;
        int        near_y;
        int        spare_ops;
        near_x    = 0;
        near_y    = 0;
        spare_ops = 0;
        i_rst_n            <= 1'b0;
        i_in_valid         <= 1'b0;
        i_operation        <= OP_CLEAR;
        i_pos_x            <= '0;
        i_pos_y            <= '0;
        i_rect_width       <= '0;
        i_rect_height      <= '0;
        i_circle_radius    <= '0;
        i_fill_byte        <= '0;
        i_border_byte      <= '0;
        i_border_thickness <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: fresh store, pixels at the corners and off screen
        offer_command(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        offer_command(make_cmd(OP_READ, 511, -512, 0, 0, 0, 0, 0, 0), 1'b0);
        offer_command(make_cmd(OP_PIXEL, 0, 0, 0, 0, 0, 'hFF, 0, 0), 1'b0);
        offer_command(make_cmd(OP_PIXEL, 63, 31, 0, 0, 0, 'h00, 0, 0), 1'b0);
        offer_command(make_cmd(OP_PIXEL, -512, 511, 0, 0, 0, 'h55, 0, 0), 1'b0);
        offer_command(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        offer_command(make_cmd(OP_READ, 63, 31, 0, 0, 0, 0, 0, 0), 1'b0);
        // rectangle with a two-cell frame: one read in the band, one inside
        offer_command(make_cmd(OP_RECT, 2, 2, 10, 6, 0, 'h41, 'h42, 2), 1'b0);
        offer_command(make_cmd(OP_READ, 3, 3, 0, 0, 0, 0, 0, 0), 1'b0);
        offer_command(make_cmd(OP_READ, 5, 4, 0, 0, 0, 0, 0, 0), 1'b0);
        // no frame, then zero width and zero height
        offer_command(make_cmd(OP_RECT, 20, 1, 5, 5, 0, 'h43, 'hAA, 0), 1'b0);
        offer_command(make_cmd(OP_RECT, 0, 0, 0, 9, 0, 'h44, 'h45, 1), 1'b0);
        offer_command(make_cmd(OP_RECT, 0, 0, 9, 0, 0, 'h46, 'h47, 1), 1'b0);
        // clipped at top left, band still taken from the unclipped edges
        offer_command(make_cmd(OP_RECT, -5, -3, 12, 8, 0, 'h30, 'h31, 3), 1'b0);
        offer_command(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        offer_command(make_cmd(OP_READ, 6, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        // circle centred at origin plus radius
        offer_command(make_cmd(OP_CIRCLE, 30, 10, 0, 0, 6, 'h61, 'h62, 2), 1'b0);
        offer_command(make_cmd(OP_READ, 36, 16, 0, 0, 0, 0, 0, 0), 1'b0);
        offer_command(make_cmd(OP_CIRCLE, 10, 20, 0, 0, 0, 'h63, 'h64, 1), 1'b0);
        // outline wider than the radius: only the exact centre keeps the fill byte
        offer_command(make_cmd(OP_CIRCLE, 40, 2, 0, 0, 5, 'h7E, 'h23, 9), 1'b0);
        offer_command(make_cmd(OP_READ, 45, 7, 0, 0, 0, 0, 0, 0), 1'b0);
        offer_command(make_cmd(OP_READ, 44, 7, 0, 0, 0, 0, 0, 0), 1'b0);
        // largest radius and sizes, far off the origin
        offer_command(make_cmd(OP_CIRCLE, -200, -200, 0, 0, 255, 'h01, 'hFE, 255), 1'b0);
        offer_command(make_cmd(OP_RECT, -512, -512, 511, 511, 0, 'h11, 'h99, 255), 1'b0);
        offer_command(make_cmd(OP_READ, 17, 9, 0, 0, 0, 0, 0, 0), 1'b0);
        // spare opcodes leave the store alone
        for (int k = OP_UNUSED_LO; k <= OP_UNUSED_HI; k++) begin
            offer_command(make_cmd(3'(k), 17, 9, 3, 3, 3, 'h00, 'h00, 1), 1'b0);
        end
        offer_command(make_cmd(OP_READ, 17, 9, 0, 0, 0, 0, 0, 0), 1'b0);
        offer_command(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        offer_command(make_cmd(OP_READ, 36, 16, 0, 0, 0, 0, 0, 0), 1'b0);

        // random: mostly small shapes near the screen, reads aimed at recent shapes
        while (commands_sent < ITEM_TARGET) begin
            if (!pressure_req && commands_sent >= ITEM_TARGET / 2) begin
                // receiver goes quiet while reads keep coming back to back
                pressure_req = 1'b1;
                for (int k = 0; k < 10; k++) begin
                    offer_command(make_cmd(OP_READ, $urandom_range(0, 63),
                                           $urandom_range(0, 31), 0, 0, 0, 0, 0, 0),
                                  k < 9);
                end
            end
            c.fill      = 8'($urandom);
            c.border    = 8'($urandom);
            c.thickness = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 4))
                                                     : 8'($urandom);
            c.width     = ($urandom_range(0, 6) == 0) ? 9'($urandom)
                                                      : 9'($urandom_range(0, 12));
            c.height    = ($urandom_range(0, 6) == 0) ? 9'($urandom)
                                                      : 9'($urandom_range(0, 12));
            c.radius    = ($urandom_range(0, 6) == 0) ? 8'($urandom)
                                                      : 8'($urandom_range(0, 10));
            if ($urandom_range(0, 4) == 0) begin
                c.pos_x = 10'($urandom);
                c.pos_y = 10'($urandom);
            end else begin
                c.pos_x = 10'($urandom_range(0, 78) - 8);
                c.pos_y = 10'($urandom_range(0, 46) - 8);
            end
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                c.op = OP_CLEAR;
            end else if (pick < 5) begin
                c.op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            end else if (pick < 15) begin
                c.op = OP_PIXEL;
            end else if (pick < 35) begin
                c.op = OP_RECT;
            end else if (pick < 52) begin
                c.op = OP_CIRCLE;
            end else begin
                c.op = OP_READ;
                if ($urandom_range(0, 1) == 0) begin
                    c.pos_x = 10'(near_x + $urandom_range(0, 12));
                    c.pos_y = 10'(near_y + $urandom_range(0, 12));
                end
            end
            if (c.op == OP_RECT || c.op == OP_CIRCLE || c.op == OP_PIXEL) begin
                near_x = int'(c.pos_x);
                near_y = int'(c.pos_y);
            end
            offer_command(c, 1'b0);
        end

        i_in_valid <= 1'b0;
        while (reads_outstanding != 0) @(posedge i_clk);
        // a trailing fill may still be running with nothing left to return
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        for (int k = OP_UNUSED_LO; k <= OP_UNUSED_HI; k++) begin
            spare_ops += sent_by_op[k];
        end
        $display("sent %0d commands: %0d clears, %0d pixels, %0d rectangles, %0d circles,"
                 , commands_sent, sent_by_op[OP_CLEAR], sent_by_op[OP_PIXEL],
                 sent_by_op[OP_RECT], sent_by_op[OP_CIRCLE]);
        $display("%0d reads (%0d cell values compared), %0d spare opcodes",
                 sent_by_op[OP_READ], cells_checked, spare_ops);
        if (fail_count == 0 && reads_outstanding == 0) begin
            $display("shape_fill_framebuffer verification clean");
        end else begin
            $display("shape_fill_framebuffer verification failed");
        end
        $finish;
    end

    // read side: stall density is redrawn whenever its current mode runs out, with quiet stretches,
    // plus one long hold-off when the stimulus asks for it
    initial begin
        int hold_left;
        int mode_left;
        int stall_pct;
        bit pressure_seen;
        hold_left     = 0;
        mode_left     = 0;
        stall_pct     = 0;
        pressure_seen = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pressure_req && !pressure_seen) begin
                pressure_seen = 1'b1;
                hold_left     = HOLD_OFF;
            end
            if (mode_left == 0) begin
                mode_left = $urandom_range(20, 200);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && i_out_stall === 1'b0)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("shape_fill_framebuffer verification failed");
            $finish;
        end
    end

endmodule
